### src/flash_image_state_classifier_macros.svh
// assertion macros for the flash image state classifier
`ifndef FLASH_IMAGE_STATE_CLASSIFIER_MACROS_SVH
`define FLASH_IMAGE_STATE_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FISC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flash image classifier check failed");

// next-cycle implication, checked out of reset
`define FISC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flash image classifier check failed");

`endif

### src/fisc_pkg.sv
// shared constants, types and the commit marker table for the image classifier
`timescale 1ns / 1ps

package fisc_pkg;

  // region and offset sizing
  localparam int MAX_REGION   = 65536;
  localparam int HEADER_BYTES = 64;
  localparam int MARKER_BYTES = 4;
  localparam int OFF_W        = $clog2(MAX_REGION) + 1;
  localparam int MARK_IDX_W   = $clog2(MARKER_BYTES);
  localparam int STATUS_W     = 13;
  localparam int BYTE_W       = 8;
  localparam int CLASS_W      = 3;

  // apb register map
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam logic REG_RECORD_LENGTH = 1'b0;
  localparam logic REG_REGION_LENGTH = 1'b1;

  localparam logic [OFF_W-1:0]  MAX_LEN     = OFF_W'(MAX_REGION);
  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hff;

  // image classes; unreadable wins, then the rest in the listed order
  typedef enum logic [CLASS_W-1:0] {
    CLS_COMMITTED   = 3'd0,
    CLS_BLANK       = 3'd1,
    CLS_UNCOMMITTED = 3'd2,
    CLS_INTERRUPTED = 3'd3,
    CLS_FOREIGN     = 3'd4,
    CLS_UNREADABLE  = 3'd5
  } class_t;

  // commit marker bytes following the record
  function automatic logic [BYTE_W-1:0] commit_mark(input logic [MARK_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = 8'h4c;  // 'L'
      2'd1:    b = 8'h37;  // '7'
      2'd2:    b = 8'h4f;  // 'O'
      2'd3:    b = 8'h4b;  // 'K'
      default: b = ERASED_BYTE;
    endcase
    return b;
  endfunction

endpackage

### src/flash_image_state_classifier.sv
// Flash image state classifier: scans a partition one byte per request and
// reports what it holds relative to one record.
// Input stream: one request per flash byte, carrying the flash byte, the record
// byte for the same offset and the read status. An internal offset counter
// builds the target image (record, commit marker, then erased bytes).
// Output stream: one class and error code after the last byte of the region,
// or at once on a read error or a region too small for record plus marker.
// Throughput: one request per cycle; the per-byte compare and flag update sit
// between the input handshake and the result register.
// Result: registered, shown in the cycle after the request that ends the scan.
// When the receiver stalls, the result register holds and the input is taken
// only if that register is free or being drained in the same cycle.
// Reset: scan offset to zero, all flags set, no result pending, record_length
// to 0 and region_length to the maximum region size.
// Configuration: APB at byte address 0 (record_length) and 4 (region_length); the user
// writes them only while the block is idle (not enforced); over-maximum lengths are clamped.
`timescale 1ns / 1ps
`include "flash_image_state_classifier_macros.svh"

module flash_image_state_classifier (
  input  logic                          clk,
  input  logic                          rst,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fisc_pkg::ADDR_W-1:0]   paddr,
  input  logic [fisc_pkg::DATA_W-1:0]   pwdata,
  output logic [fisc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // byte stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // flash_byte, record_byte, read_status
  // class stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata   // image_class, error_code
);
  import fisc_pkg::*;

  logic [OFF_W-1:0]           record_length;
  logic [OFF_W-1:0]           region_length;
  logic [OFF_W-1:0]           scan_offset;
  logic                       exact_flag;
  logic                       erased_flag;
  logic                       uncommitted_flag;
  logic                       header_flag;
  logic                       consistent_flag;
  class_t                     image_class;
  logic signed [STATUS_W-1:0] error_code;

  logic                       cfg_write;
  logic                       in_acc;
  logic [BYTE_W-1:0]          flash_byte;
  logic [BYTE_W-1:0]          record_byte;
  logic signed [STATUS_W-1:0] read_status;
  logic [OFF_W-1:0]           rec_eff;
  logic [OFF_W-1:0]           reg_eff;
  logic                       too_small;
  logic                       read_err;
  logic [OFF_W-1:0]           off_rel;
  logic                       in_record;
  logic [BYTE_W-1:0]          target;
  logic                       exact_next;
  logic                       erased_next;
  logic                       uncommitted_next;
  logic                       header_next;
  logic                       consistent_next;
  logic [OFF_W-1:0]           offset_next;
  logic                       scan_done;
  logic                       emit_now;
  class_t                     class_next;
  logic signed [STATUS_W-1:0] error_next;

  // request fields
  assign flash_byte  = s_axis_tdata[7:0];
  assign record_byte = s_axis_tdata[15:8];
  assign read_status = s_axis_tdata[28:16];

  // apb access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_REGION_LENGTH) ? DATA_W'(region_length)
                                                     : DATA_W'(record_length);

  // handshakes
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {error_code, image_class};

  // clamped lengths and early-out checks
  assign rec_eff   = (record_length > MAX_LEN) ? MAX_LEN : record_length;
  assign reg_eff   = (region_length > MAX_LEN) ? MAX_LEN : region_length;
  assign too_small = {1'b0, reg_eff} < ({1'b0, rec_eff} + (OFF_W+1)'(MARKER_BYTES));
  assign read_err  = read_status != '0;

  // target byte at the current offset
  assign in_record = scan_offset < rec_eff;
  assign off_rel   = scan_offset - rec_eff;
  always_comb begin
    if (in_record) begin
      target = record_byte;
    end else if (off_rel < OFF_W'(MARKER_BYTES)) begin
      target = commit_mark(off_rel[MARK_IDX_W-1:0]);
    end else begin
      target = ERASED_BYTE;
    end
  end

  // flag update for this byte
  always_comb begin
    exact_next       = exact_flag && (flash_byte == target);
    erased_next      = erased_flag && (flash_byte == ERASED_BYTE);
    uncommitted_next = uncommitted_flag &&
                       (in_record ? (flash_byte == target) : (flash_byte == ERASED_BYTE));
    header_next      = header_flag;
    consistent_next  = consistent_flag;
    if (scan_offset < OFF_W'(HEADER_BYTES)) begin
      header_next = header_flag && (flash_byte == target);
    end else begin
      consistent_next = consistent_flag && ((flash_byte & target) == target);
    end
  end

  assign offset_next = scan_offset + OFF_W'(1);
  assign scan_done   = offset_next >= reg_eff;
  assign emit_now    = too_small || read_err || scan_done;

  // class selection by priority
  always_comb begin
    error_next = '0;
    if (too_small) begin
      class_next = CLS_UNREADABLE;
    end else if (read_err) begin
      class_next = CLS_UNREADABLE;
      error_next = read_status;
    end else if (exact_next) begin
      class_next = CLS_COMMITTED;
    end else if (erased_next) begin
      class_next = CLS_BLANK;
    end else if (uncommitted_next) begin
      class_next = CLS_UNCOMMITTED;
    end else if (header_next && consistent_next) begin
      class_next = CLS_INTERRUPTED;
    end else begin
      class_next = CLS_FOREIGN;
    end
  end

  // control state, configuration and scan flags
  always_ff @(posedge clk) begin
    if (rst) begin
      record_length    <= '0;
      region_length    <= MAX_LEN;
      scan_offset      <= '0;
      exact_flag       <= 1'b1;
      erased_flag      <= 1'b1;
      uncommitted_flag <= 1'b1;
      header_flag      <= 1'b1;
      consistent_flag  <= 1'b1;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == REG_REGION_LENGTH) begin
          region_length <= pwdata[OFF_W-1:0];
        end else begin
          record_length <= pwdata[OFF_W-1:0];
        end
      end
      if (in_acc && emit_now) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_acc) begin
        if (emit_now) begin
          scan_offset      <= '0;
          exact_flag       <= 1'b1;
          erased_flag      <= 1'b1;
          uncommitted_flag <= 1'b1;
          header_flag      <= 1'b1;
          consistent_flag  <= 1'b1;
        end else begin
          scan_offset      <= offset_next;
          exact_flag       <= exact_next;
          erased_flag      <= erased_next;
          uncommitted_flag <= uncommitted_next;
          header_flag      <= header_next;
          consistent_flag  <= consistent_next;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && emit_now) begin
      image_class <= class_next;
      error_code  <= error_next;
    end
  end

  // checks
  `FISC_ASSERT_NOW(a_offset_in_range, 1'b1, scan_offset < MAX_LEN)
  `FISC_ASSERT_NOW(a_error_only_unreadable, m_axis_tvalid && (error_code != '0),
                   image_class == CLS_UNREADABLE)
  `FISC_ASSERT_NEXT(a_read_error_reported, in_acc && !too_small && read_err,
                    m_axis_tvalid && (image_class == CLS_UNREADABLE) &&
                    (error_code == $past(read_status)))
  `FISC_ASSERT_NEXT(a_restart_after_result, in_acc && emit_now,
                    (scan_offset == '0) && exact_flag && erased_flag && header_flag)

endmodule

### sim/tb_top.sv
// self-checking testbench for the flash image state classifier
`timescale 1ns / 1ps

module tb_top;
  import fisc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 4;
  localparam int PHASE_BYTES  = 88;
  localparam int RAND_PHASES  = 12;
  localparam int IDLE_PCT     = 26;

  localparam logic [7:0]  ERASED     = 8'hff;
  localparam logic [12:0] ST_OK      = 13'h0000;
  localparam logic [12:0] ST_WORST   = 13'h1001;  // -4095
  localparam logic [12:0] ST_MINUS_1 = 13'h1fff;  // -1
  localparam logic [7:0]  COMMIT_MARK [0:3] = '{8'h4c, 8'h37, 8'h4f, 8'h4b};  // L 7 O K

  // how the flash content of one generated scan relates to its target image
  typedef enum logic [2:0] {
    SCAN_EXACT, SCAN_BLANK, SCAN_UNCOMMITTED, SCAN_INTERRUPTED, SCAN_NOISE, SCAN_CORRUPT
  } scan_kind_t;

  typedef struct packed {
    class_t      cls;
    logic [12:0] err;
  } image_result_t;

  // one directed step: a register write or one flash byte
  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    logic [31:0] value;
    logic [7:0]  fb;
    logic [7:0]  rb;
    logic [12:0] st;
    bit          typed;
    class_t      cls;
    logic [12:0] err;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // flash_byte, record_byte, read_status
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // image_class, error_code

  // predictor state and register shadows
  logic [16:0] cfg_record;
  logic [16:0] cfg_region;
  int          scan_pos;
  bit          ok_exact, ok_erased, ok_uncommitted, ok_header, ok_consistent;
  scan_kind_t  scan_kind;

  image_result_t class_q[$];
  dir_row_t      dir_rows[$];
  int  bytes_sent = 0;
  int  classes_checked = 0;
  int  settings_used = 0;
  int  class_hits [0:7];
  int  errors = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  flash_image_state_classifier DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d classes still pending", cycle_count,
               class_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int clamp_len(input logic [16:0] v);
    return (v > MAX_REGION) ? MAX_REGION : int'(v);
  endfunction

  function automatic logic [7:0] image_byte(input int off, input int rec_n,
                                            input logic [7:0] rb);
    if (off < rec_n) return rb;
    if (off - rec_n < MARKER_BYTES) return COMMIT_MARK[off - rec_n];
    return ERASED;
  endfunction

  function automatic void restart_scan();
    scan_pos       = 0;
    ok_exact       = 1'b1;
    ok_erased      = 1'b1;
    ok_uncommitted = 1'b1;
    ok_header      = 1'b1;
    ok_consistent  = 1'b1;
  endfunction

  // one flash byte through the classifier; returns 1 when a class comes out
  function automatic bit classify_byte(input logic [7:0] fb, input logic [7:0] rb,
                                       input logic [12:0] st, output image_result_t res);
    int rec_n;
    int region_n;
    int off;
    logic [7:0] tgt;
    rec_n    = clamp_len(cfg_record);
    region_n = clamp_len(cfg_region);
    res      = '{CLS_UNREADABLE, 13'd0};
    // region too small is checked ahead of the read status
    if (region_n < rec_n + MARKER_BYTES) begin
      restart_scan();
      return 1'b1;
    end
    if (st != ST_OK) begin
      res.err = st;
      restart_scan();
      return 1'b1;
    end
    off = scan_pos;
    tgt = image_byte(off, rec_n, rb);
    ok_exact       &= (fb == tgt);
    ok_erased      &= (fb == ERASED);
    ok_uncommitted &= (off < rec_n) ? (fb == tgt) : (fb == ERASED);
    if (off < HEADER_BYTES) ok_header &= (fb == tgt);
    else ok_consistent &= ((fb & tgt) == tgt);
    scan_pos = off + 1;
    if (scan_pos < region_n) return 1'b0;
    // priority order of the classes
    if (ok_exact) res.cls = CLS_COMMITTED;
    else if (ok_erased) res.cls = CLS_BLANK;
    else if (ok_uncommitted) res.cls = CLS_UNCOMMITTED;
    else if (ok_header && ok_consistent) res.cls = CLS_INTERRUPTED;
    else res.cls = CLS_FOREIGN;
    restart_scan();
    return 1'b1;
  endfunction

  // flash content for the next offset, shaped by the kind of the current scan
  function automatic logic [7:0] next_flash(input logic [7:0] rb);
    int rec_n;
    logic [7:0] tgt;
    rec_n = clamp_len(cfg_record);
    if (scan_pos == 0) scan_kind = scan_kind_t'($urandom_range(0, 5));
    tgt = image_byte(scan_pos, rec_n, rb);
    case (scan_kind)
      SCAN_EXACT:       return tgt;
      SCAN_BLANK:       return ERASED;
      SCAN_UNCOMMITTED: return (scan_pos < rec_n) ? tgt : ERASED;
      SCAN_INTERRUPTED: return (scan_pos < HEADER_BYTES) ? tgt : (tgt | 8'($urandom));
      SCAN_CORRUPT:
        return ($urandom_range(0, 29) == 0) ? (tgt ^ (8'h01 << $urandom_range(0, 7))) : tgt;
      default:          return 8'($urandom);
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input logic idx, input logic [31:0] v);
    dir_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = v;
    r.fb      = 8'd0;
    r.rb      = 8'd0;
    r.st      = ST_OK;
    r.typed   = 1'b0;
    r.cls     = CLS_COMMITTED;
    r.err     = 13'd0;
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] fb, input logic [7:0] rb,
                                        input logic [12:0] st, input bit typed,
                                        input class_t c, input logic [12:0] e);
    dir_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = 1'b0;
    r.value   = 32'd0;
    r.fb = fb; r.rb = rb; r.st = st;
    r.typed = typed; r.cls = c; r.err = e;
    return r;
  endfunction

  // stop offering and wait until every pending class has been checked
  task automatic drain_classes();
    s_tvalid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // apb write while the block is idle, then read the register back
  task automatic apb_write(input logic idx, input logic [31:0] v);
    drain_classes();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_RECORD_LENGTH) cfg_record = v[16:0];
    else cfg_region = v[16:0];
    settings_used++;
    @(negedge clk);
    if (prdata !== 32'(v[16:0])) begin
      $display("%0t: register %0d readback expected %0h got %0h", $time, idx, v[16:0],
               prdata);
      errors++;
    end
    @(posedge clk);
  endtask

  // offer one byte request and predict its class once accepted
  task automatic send_byte(input logic [7:0] fb, input logic [7:0] rb,
                           input logic [12:0] st, input bit typed,
                           input image_result_t typed_res);
    image_result_t res;
    bit emitted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, st, rb, fb};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    bytes_sent++;
    emitted = classify_byte(fb, rb, st, res);
    if (typed) class_q.push_back(typed_res);
    else if (emitted) class_q.push_back(res);
  endtask

  task automatic send_random_byte();
    logic [7:0]  rb;
    logic [7:0]  fb;
    logic [12:0] st;
    rb = 8'($urandom);
    fb = next_flash(rb);
    st = ST_OK;
    if ($urandom_range(0, 99) < 2) st = 13'(-$urandom_range(1, 4095));
    send_byte(fb, rb, st, 1'b0, '{CLS_COMMITTED, 13'd0});
  endtask

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // compare each accepted class against the oldest prediction
  always @(negedge clk) begin
    image_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (class_q.size() == 0) begin
        $display("%0t: class %0d err %0d with no scan pending", $time, m_tdata[2:0],
                 $signed(m_tdata[15:3]));
        errors++;
      end else begin
        want = class_q.pop_front();
        classes_checked++;
        class_hits[m_tdata[2:0]]++;
        if (m_tdata[2:0] !== want.cls) begin
          $display("%0t: image_class expected %0d got %0d", $time, want.cls, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[15:3] !== want.err) begin
          $display("%0t: error_code expected %0d got %0d", $time, $signed(want.err),
                   $signed(m_tdata[15:3]));
          errors++;
        end
      end
    end
  end

  initial begin
    int rec_n;
    int pick;
    logic [31:0] rec_v;
    logic [31:0] region_v;
    foreach (class_hits[i]) class_hits[i] = 0;
    cfg_record = 17'd0;
    cfg_region = 17'(MAX_REGION);
    scan_kind  = SCAN_EXACT;
    restart_scan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table: reset settings, oversized lengths, region too small, five classes
    dir_rows.push_back(byte_row(8'h00, 8'h00, ST_WORST, 1, CLS_UNREADABLE, ST_WORST));
    dir_rows.push_back(byte_row(8'hff, 8'hff, ST_MINUS_1, 1, CLS_UNREADABLE, ST_MINUS_1));
    dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(cfg_row(REG_RECORD_LENGTH, 32'h0001_0000));
    dir_rows.push_back(byte_row(8'hff, 8'hff, ST_OK, 1, CLS_UNREADABLE, 13'd0));
    // size check wins over a read error
    dir_rows.push_back(byte_row(8'h00, 8'h00, ST_WORST, 1, CLS_UNREADABLE, 13'd0));
    dir_rows.push_back(cfg_row(REG_RECORD_LENGTH, 32'h0001_ffff));
    dir_rows.push_back(cfg_row(REG_REGION_LENGTH, 32'h0001_ffff));
    dir_rows.push_back(byte_row(8'h4c, 8'h00, ST_OK, 1, CLS_UNREADABLE, 13'd0));
    dir_rows.push_back(cfg_row(REG_RECORD_LENGTH, 32'h0000_0000));
    dir_rows.push_back(cfg_row(REG_REGION_LENGTH, 32'h0000_0000));
    dir_rows.push_back(byte_row(8'hff, 8'hff, ST_OK, 1, CLS_UNREADABLE, 13'd0));
    // marker-only region
    dir_rows.push_back(cfg_row(REG_REGION_LENGTH, 32'h0000_0004));
    dir_rows.push_back(byte_row(8'h4c, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'h37, 8'hff, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'h4f, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'h4b, 8'hff, ST_OK, 1, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 1, CLS_BLANK, 13'd0));
    // one record byte, marker never written
    dir_rows.push_back(cfg_row(REG_RECORD_LENGTH, 32'h0000_0001));
    dir_rows.push_back(cfg_row(REG_REGION_LENGTH, 32'h0000_0005));
    dir_rows.push_back(byte_row(8'ha5, 8'ha5, ST_OK, 0, CLS_COMMITTED, 13'd0));
    repeat (3) dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 1, CLS_UNCOMMITTED, 13'd0));
    // wrong record byte in the header
    dir_rows.push_back(byte_row(8'h00, 8'h5a, ST_OK, 0, CLS_COMMITTED, 13'd0));
    repeat (3) dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 0, CLS_COMMITTED, 13'd0));
    dir_rows.push_back(byte_row(8'hff, 8'h00, ST_OK, 1, CLS_FOREIGN, 13'd0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) apb_write(dir_rows[i].reg_idx, dir_rows[i].value);
      else send_byte(dir_rows[i].fb, dir_rows[i].rb, dir_rows[i].st, dir_rows[i].typed,
                     '{dir_rows[i].cls, dir_rows[i].err});
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = (ph == 3) ? 0 : $urandom_range(0, 9);
      rec_n = $urandom_range(0, 8);
      region_v = 32'(rec_n + MARKER_BYTES + $urandom_range(0, 12));
      case (pick)
        0: begin
          rec_n = $urandom_range(0, 40);
          region_v = 32'($urandom_range(0, rec_n + MARKER_BYTES - 1));
        end
        1: rec_n = MAX_REGION + $urandom_range(1, 65535);
        5, 6, 7: begin
          rec_n = $urandom_range(0, 20);
          region_v = 32'(rec_n + MARKER_BYTES + $urandom_range(0, 30));
        end
        8, 9: begin
          rec_n = $urandom_range(0, 70);
          region_v = 32'($urandom_range(rec_n + MARKER_BYTES > 65 ? rec_n + MARKER_BYTES : 65,
                                        100));
        end
        default: ;
      endcase
      // junk above the 17 register bits
      rec_v = {15'($urandom), 17'(rec_n)};
      region_v = {15'($urandom), region_v[16:0]};
      if ($urandom_range(0, 1) == 1) begin
        apb_write(REG_RECORD_LENGTH, rec_v);
        apb_write(REG_REGION_LENGTH, region_v);
      end else begin
        apb_write(REG_REGION_LENGTH, region_v);
        apb_write(REG_RECORD_LENGTH, rec_v);
      end
      calm = (ph == 6);
      // long receiver hold-off while every byte produces a class
      if (ph == 3) hold_req = 1'b1;
      repeat (PHASE_BYTES) send_random_byte();
    end
    calm = 1'b0;

    drain_classes();
    repeat (10) @(posedge clk);
    $display("scanned %0d bytes under %0d register writes, %0d classes checked", bytes_sent,
             settings_used, classes_checked);
    $display("classes seen: committed %0d blank %0d uncommitted %0d",
             class_hits[0], class_hits[1], class_hits[2]);
    $display("  interrupted %0d foreign %0d unreadable %0d",
             class_hits[3], class_hits[4], class_hits[5]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/fisc_pkg.sv
src/flash_image_state_classifier.sv
sim/tb_top.sv
